// ----- rtl/bdfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot download frame receiver package
// Shared types, register map, reset values and protocol constants.
// ----------------------------------------------------------------------------
package bdfr_pkg;

	// Largest frame length that the byte counter tracks before it saturates.
	localparam int unsigned MAX_FRAME_BYTES_DEF = 2048;

	// Configuration port geometry: five 32-bit registers on a word grid.
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_ADDR_W = 5;

	// Frame constants.
	localparam logic [7:0] HDR_SYNC   = 8'hAA;
	localparam logic [7:0] REPLY_SYNC = 8'h55;
	localparam logic [7:0] MIN_STATION = 8'd2;

	// Register reset values.
	localparam logic [7:0]  RST_STATION     = 8'd2;
	localparam logic [7:0]  RST_CODE_BOOT   = 8'd1;
	localparam logic [7:0]  RST_CODE_ERASE  = 8'd2;
	localparam logic [7:0]  RST_CODE_DATA   = 8'd3;
	localparam logic [15:0] RST_MAX_PAYLOAD = 16'd1024;

	typedef enum logic [2:0] {
		REG_STATION     = 3'd0,
		REG_CODE_BOOT   = 3'd1,
		REG_CODE_ERASE  = 3'd2,
		REG_CODE_DATA   = 3'd3,
		REG_MAX_PAYLOAD = 3'd4
	} cfg_reg_e;

	typedef enum logic [1:0] {
		REPLY_NONE     = 2'd0,
		REPLY_BOOT     = 2'd1,
		REPLY_ERASE    = 2'd2,
		REPLY_DATA_ACK = 2'd3
	} reply_kind_e;

	typedef enum logic [1:0] {
		DL_IDLE        = 2'd0,
		DL_BOOT        = 2'd1,
		DL_ERASING     = 2'd2,
		DL_PROGRAMMING = 2'd3
	} dl_status_e;

	typedef struct packed {
		logic [7:0]  station_address;
		logic [7:0]  code_enter_boot;
		logic [7:0]  code_erase;
		logic [7:0]  code_data;
		logic [15:0] max_payload;
	} cfg_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_end;
	} in_item_t;

	typedef struct packed {
		logic        frame_accepted;
		logic [1:0]  reply_kind;
		logic [1:0]  download_status;
		logic [7:0]  packet_number;
		logic [7:0]  packet_total;
		logic [15:0] payload_length;
		logic        program_packet;
		logic        download_done;
		logic [7:0]  reply_checksum;
	} out_item_t;

	// What the frame accumulator knows about the frame so far.
	typedef struct packed {
		logic            len_cmd_ok;   // at least four bytes before the checksum
		logic            len_data_ok;  // at least eight bytes before the checksum
		logic            len_in_range; // count has not saturated
		logic [7:0]      running_sum;
		logic [7:0][7:0] hdr;          // header bytes, hdr[0] first
	} frame_info_t;

endpackage

// ----- rtl/bdfr_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file for station address, command codes and payload limit.
// ----------------------------------------------------------------------------
module bdfr_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bdfr_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [bdfr_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [bdfr_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                             pready,
	output bdfr_pkg::cfg_t                   cfg
);
	import bdfr_pkg::*;

	cfg_t     cfg_q;
	cfg_reg_e reg_sel;
	logic     wr_en;

	assign reg_sel = cfg_reg_e'(paddr[CFG_ADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.station_address <= RST_STATION;
			cfg_q.code_enter_boot <= RST_CODE_BOOT;
			cfg_q.code_erase      <= RST_CODE_ERASE;
			cfg_q.code_data       <= RST_CODE_DATA;
			cfg_q.max_payload     <= RST_MAX_PAYLOAD;
		end else if (wr_en) begin
			case (reg_sel)
				REG_STATION:     cfg_q.station_address <= pwdata[7:0];
				REG_CODE_BOOT:   cfg_q.code_enter_boot <= pwdata[7:0];
				REG_CODE_ERASE:  cfg_q.code_erase      <= pwdata[7:0];
				REG_CODE_DATA:   cfg_q.code_data       <= pwdata[7:0];
				REG_MAX_PAYLOAD: cfg_q.max_payload     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_STATION:     prdata = {24'd0, cfg_q.station_address};
			REG_CODE_BOOT:   prdata = {24'd0, cfg_q.code_enter_boot};
			REG_CODE_ERASE:  prdata = {24'd0, cfg_q.code_erase};
			REG_CODE_DATA:   prdata = {24'd0, cfg_q.code_data};
			REG_MAX_PAYLOAD: prdata = {16'd0, cfg_q.max_payload};
			default:         prdata = '0;
		endcase
	end

endmodule

// ----- rtl/bdfr_frame_acc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame accumulator
// Counts frame bytes, keeps the running 8-bit sum and the first eight bytes.
// ----------------------------------------------------------------------------
module bdfr_frame_acc #(
	parameter int unsigned MAX_FRAME_BYTES = bdfr_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_en,
	input  logic                  frame_clear,
	input  logic [7:0]            rx_byte,
	output bdfr_pkg::frame_info_t info
);
	import bdfr_pkg::*;

	localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

	logic [POS_W-1:0] pos_q;
	logic [7:0]       sum_q;
	logic [7:0][7:0]  hdr_q;
	logic             in_hdr;

	assign in_hdr = (pos_q[POS_W-1:3] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (frame_clear) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (byte_en) begin
			sum_q <= sum_q + rx_byte;
			if (pos_q < POS_MAX) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// Header bytes need no reset: each is written before it is looked at.
	always_ff @(posedge clk) begin
		if (byte_en && in_hdr) begin
			hdr_q[pos_q[2:0]] <= rx_byte;
		end
	end

	assign info.len_cmd_ok   = (pos_q >= POS_W'(4));
	assign info.len_data_ok  = (pos_q >= POS_W'(8));
	assign info.len_in_range = (pos_q < POS_MAX);
	assign info.running_sum  = sum_q;
	assign info.hdr          = hdr_q;

endmodule

// ----- rtl/bdfr_cmd_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command evaluator
// Checks a finished frame, acts on its command and keeps the download status.
// ----------------------------------------------------------------------------
module bdfr_cmd_eval (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  eval_en,
	input  logic [7:0]            rx_byte,
	input  bdfr_pkg::frame_info_t info,
	input  bdfr_pkg::cfg_t        cfg,
	output bdfr_pkg::out_item_t   result
);
	import bdfr_pkg::*;

	dl_status_e status_q;
	logic [7:0] last_q;

	dl_status_e  status_d;
	logic [7:0]  last_d;
	logic [7:0]  cmd;
	logic        hdr_ok;
	logic        frame_ok;
	logic        is_boot;
	logic        is_erase;
	logic        is_data;
	logic [7:0]  pnum;
	logic [7:0]  ptot;
	logic [15:0] plen;
	logic        in_order;
	logic        dup;
	logic        pkt_ok;
	logic [7:0]  sync_sum;
	logic [7:0]  code_sel;

	always_comb begin
		cmd      = info.hdr[3];
		is_boot  = (cmd == cfg.code_enter_boot);
		is_erase = !is_boot && (cmd == cfg.code_erase);
		is_data  = !is_boot && !is_erase && (cmd == cfg.code_data);

		hdr_ok = info.len_cmd_ok && info.len_in_range
			&& (cfg.station_address >= MIN_STATION)
			&& (info.hdr[0] == HDR_SYNC) && (info.hdr[1] == HDR_SYNC)
			&& (info.hdr[2] == cfg.station_address)
			&& (rx_byte == info.running_sum);
		// A data frame must also carry the four packet header bytes.
		frame_ok = hdr_ok && !(is_data && !info.len_data_ok);

		ptot     = info.hdr[4];
		pnum     = info.hdr[5];
		plen     = {info.hdr[7], info.hdr[6]};
		pkt_ok   = (plen <= cfg.max_payload) && (pnum <= ptot);
		in_order = (({1'b0, last_q} + 9'd1) == {1'b0, pnum});
		dup      = (last_q == pnum);

		status_d = status_q;
		last_d   = last_q;
		result   = '0;

		if (frame_ok) begin
			if (is_boot) begin
				status_d              = DL_BOOT;
				last_d                = '0;
				result.frame_accepted = 1'b1;
				result.reply_kind     = REPLY_BOOT;
			end else if (is_erase) begin
				status_d              = DL_ERASING;
				last_d                = '0;
				result.frame_accepted = 1'b1;
				result.reply_kind     = REPLY_ERASE;
			end else if (is_data &&
					(status_q == DL_ERASING || status_q == DL_PROGRAMMING)) begin
				result.packet_number  = pnum;
				result.packet_total   = ptot;
				result.payload_length = plen;
				if (pkt_ok && in_order) begin
					last_d                = pnum;
					result.frame_accepted = 1'b1;
					result.reply_kind     = REPLY_DATA_ACK;
					result.program_packet = 1'b1;
					if (pnum == ptot) begin
						result.download_done = 1'b1;
						status_d             = DL_IDLE;
					end else begin
						status_d = DL_PROGRAMMING;
					end
				end else if (pkt_ok && dup) begin
					result.frame_accepted = 1'b1;
					result.reply_kind     = REPLY_DATA_ACK;
					status_d              = DL_PROGRAMMING;
				end
			end else begin
				// Unknown command, or data outside a download: drop back to idle.
				status_d              = DL_IDLE;
				result.frame_accepted = 1'b1;
			end
		end

		result.download_status = status_d;

		sync_sum = REPLY_SYNC + REPLY_SYNC + cfg.station_address;
		case (reply_kind_e'(result.reply_kind))
			REPLY_BOOT:     code_sel = cfg.code_enter_boot;
			REPLY_ERASE:    code_sel = cfg.code_erase;
			REPLY_DATA_ACK: code_sel = cfg.code_data + pnum;
			default:        code_sel = '0;
		endcase
		result.reply_checksum = (result.reply_kind == REPLY_NONE) ? 8'd0
			: sync_sum + code_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= DL_IDLE;
			last_q   <= '0;
		end else if (eval_en) begin
			status_q <= status_d;
			last_q   <= last_d;
		end
	end

endmodule

// ----- rtl/boot_download_frame_receiver_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot download frame receiver
// Slave-side frame checker and command handler for a serial firmware download.
// ----------------------------------------------------------------------------
// Each item on the input channel is one received frame byte; the byte marked
// with frame_end is the frame's checksum. The block takes one item per clock
// cycle while in_stall is low. Items are registered on acceptance; a frame's
// checksum byte is evaluated from that input register into the output
// register, and bytes other than the checksum produce no result. The output
// register decouples the two channels: while a result waits to be taken,
// ordinary frame bytes keep flowing, and only a further checksum byte has to
// wait for the output register to free up. The station address, the three
// command codes and the payload limit are to be written through the APB port
// only while no frame is in flight, which the block does not enforce; they
// reset to station 2, codes 1, 2 and 3, and a limit of 1024 bytes. The byte
// counter saturates at MAX_FRAME_BYTES; longer frames are rejected.
// ----------------------------------------------------------------------------
module boot_download_frame_receiver_unit #(
	parameter int unsigned MAX_FRAME_BYTES = bdfr_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration port.
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bdfr_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [bdfr_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [bdfr_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	// Received bytes.
	input  logic                            in_valid,
	output logic                            in_stall,
	input  bdfr_pkg::in_item_t              in_item,
	// Frame results.
	output logic                            out_valid,
	input  logic                            out_stall,
	output bdfr_pkg::out_item_t             out_item
);
	import bdfr_pkg::*;

	cfg_t        cfg;
	frame_info_t info;
	out_item_t   result;

	// Input register.
	logic        valid_s1;
	in_item_t    item_s1;

	// Output register.
	logic        out_valid_q;
	out_item_t   out_item_q;

	logic        advance;
	logic        eval_en;

	// The registered byte moves on unless it is a checksum byte and the
	// output register still holds a result that has not been taken.
	assign advance  = valid_s1 & (~item_s1.frame_end | ~out_valid_q | ~out_stall);
	assign eval_en  = advance & item_s1.frame_end;
	assign in_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	bdfr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bdfr_frame_acc #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_en     (advance & ~item_s1.frame_end),
		.frame_clear (eval_en),
		.rx_byte     (item_s1.rx_byte),
		.info        (info)
	);

	bdfr_cmd_eval u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.eval_en (eval_en),
		.rx_byte (item_s1.rx_byte),
		.info    (info),
		.cfg     (cfg),
		.result  (result)
	);

	// A new result is only loaded when the register is empty or being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eval_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eval_en) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ----- rtl/bdfr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Concurrent checks on the result channel of the frame receiver.
// ----------------------------------------------------------------------------
module bdfr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input bdfr_pkg::out_item_t out_item
);
	import bdfr_pkg::*;

	// A held result stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// A rejected frame never asks for a reply.
	a_reject_no_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.frame_accepted |-> out_item.reply_kind == REPLY_NONE)
		else $error("reply requested for a rejected frame");

	// No reply means no reply checksum.
	a_no_reply_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.reply_kind == REPLY_NONE |-> out_item.reply_checksum == 8'd0)
		else $error("checksum given without a reply");

	// Programming only happens for an accepted, acknowledged data packet.
	a_program_ack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.program_packet
			|-> out_item.frame_accepted && out_item.reply_kind == REPLY_DATA_ACK)
		else $error("packet programmed without an ack");

	// The last packet ends the download and returns the status to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.download_done
			|-> out_item.program_packet && out_item.download_status == DL_IDLE)
		else $error("download done without programming and idle status");

endmodule

bind boot_download_frame_receiver_unit bdfr_checker u_bdfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
